// ----- rtl/bilinear_pixel_sampler_assert.svh -----
// ----------------------------------------------------------------------------
// bilinear pixel sampler assertion macros
// shared property forms for the sampler's checker
// ----------------------------------------------------------------------------
`ifndef BILINEAR_PIXEL_SAMPLER_ASSERT_SVH
`define BILINEAR_PIXEL_SAMPLER_ASSERT_SVH

// same-cycle implication
`define BPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bilinear pixel sampler package
// shared constants, register codes and interface structs
// ----------------------------------------------------------------------------
package bps_pkg;

   // default geometry and fixed-point format
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_FRAC_BITS  = 8;

   // register and field widths
   localparam int SIZE_W     = 9;
   localparam int COUNT_W    = 3;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int COORD_W    = 18;
   localparam int PIX_W      = 32;
   localparam int CHANNELS   = 4;
   localparam int CHAN_W     = 8;

   localparam logic [CHAN_W-1:0]  PIX_MAX   = 8'd255;
   localparam logic [COUNT_W-1:0] CHAN_MAX  = 3'd4;

   // register reset values
   localparam logic [SIZE_W-1:0]  RST_WIDTH  = 9'd256;
   localparam logic [SIZE_W-1:0]  RST_HEIGHT = 9'd256;
   localparam logic [COUNT_W-1:0] RST_COUNT  = 3'd4;

   // register index (byte address / 4)
   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH   = 2'd0,
      REG_IMAGE_HEIGHT  = 2'd1,
      REG_CHANNEL_COUNT = 2'd2
   } bps_reg_type;

   // input command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // the four neighbor coordinates of a sample
   typedef struct packed {
      logic [SIZE_W-1:0] c0;
      logic [SIZE_W-1:0] c1;
      logic [SIZE_W-1:0] r0;
      logic [SIZE_W-1:0] r1;
   } bps_nbr_type;

   // accumulator control
   typedef struct packed {
      logic clear;
      logic accum;
   } bps_mac_ctl_type;

endpackage

// ----- rtl/bps_ram.sv -----
// ----------------------------------------------------------------------------
// bps ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module bps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/bps_coord.sv -----
// ----------------------------------------------------------------------------
// bps coordinate unit
// clamps a sample location to the image and finds its four neighbors
// ----------------------------------------------------------------------------
module bps_coord #(
   parameter int MAX_WIDTH  = bps_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bps_pkg::DEF_MAX_HEIGHT,
   parameter int FRAC_BITS  = bps_pkg::DEF_FRAC_BITS
) (
   input  logic signed [bps_pkg::COORD_W-1:0] sample_x,
   input  logic signed [bps_pkg::COORD_W-1:0] sample_y,
   input  logic [bps_pkg::SIZE_W-1:0]         width_cfg,
   input  logic [bps_pkg::SIZE_W-1:0]         height_cfg,
   output bps_pkg::bps_nbr_type               nbr,
   output logic [FRAC_BITS-1:0]               frac_x,
   output logic [FRAC_BITS-1:0]               frac_y
);

   localparam int SW = bps_pkg::SIZE_W;
   localparam int XW = ((SW + FRAC_BITS > bps_pkg::COORD_W) ?
                        SW + FRAC_BITS : bps_pkg::COORD_W) + 1;

   function automatic logic [SW-1:0] sat_size(logic [SW-1:0] v, int max_size);
      logic [SW-1:0] r;
      if (v == '0) r = SW'(1);
      else if (32'(v) > max_size) r = SW'(max_size);
      else r = v;
      return r;
   endfunction

   function automatic logic signed [XW-1:0] clamp_coord(logic signed [XW-1:0] v,
                                                        logic [SW-1:0] size);
      logic signed [XW-1:0] top;
      logic signed [XW-1:0] r;
      top = signed'(XW'({size - SW'(1), {FRAC_BITS{1'b0}}}));
      if (v < 0) r = '0;
      else if (v > top) r = top;
      else r = v;
      return r;
   endfunction

   function automatic logic [SW-1:0] next_idx(logic [SW-1:0] i, logic [SW-1:0] size);
      logic [SW:0] inc;
      logic [SW-1:0] r;
      inc = {1'b0, i} + (SW+1)'(1);
      // last column or row repeats; its weight is zero there
      if (inc < {1'b0, size}) r = inc[SW-1:0];
      else r = size - SW'(1);
      return r;
   endfunction

   logic [SW-1:0]        w_sat;
   logic [SW-1:0]        h_sat;
   logic signed [XW-1:0] x_cl;
   logic signed [XW-1:0] y_cl;

   assign w_sat = sat_size(width_cfg, MAX_WIDTH);
   assign h_sat = sat_size(height_cfg, MAX_HEIGHT);
   assign x_cl  = clamp_coord(XW'(sample_x), w_sat);
   assign y_cl  = clamp_coord(XW'(sample_y), h_sat);

   assign nbr.c0 = x_cl[FRAC_BITS +: SW];
   assign nbr.r0 = y_cl[FRAC_BITS +: SW];
   assign nbr.c1 = next_idx(x_cl[FRAC_BITS +: SW], w_sat);
   assign nbr.r1 = next_idx(y_cl[FRAC_BITS +: SW], h_sat);
   assign frac_x = x_cl[FRAC_BITS-1:0];
   assign frac_y = y_cl[FRAC_BITS-1:0];

endmodule

// ----- rtl/bps_mac.sv -----
// ----------------------------------------------------------------------------
// bps accumulator
// four-channel weighted accumulate with floor and clamp
// ----------------------------------------------------------------------------
module bps_mac #(
   parameter int FRAC_BITS = bps_pkg::DEF_FRAC_BITS
) (
   input  logic                            clock,
   input  bps_pkg::bps_mac_ctl_type        ctl,
   input  logic [bps_pkg::PIX_W-1:0]       pix,
   input  logic [2*FRAC_BITS:0]            weight,
   input  logic [bps_pkg::COUNT_W-1:0]     chan_n,
   output logic [bps_pkg::PIX_W-1:0]       result
);

   localparam int CW    = bps_pkg::CHAN_W;
   localparam int NCH   = bps_pkg::CHANNELS;
   localparam int PW    = 2*FRAC_BITS + 1 + CW;
   localparam int ACC_W = 2*FRAC_BITS + CW + 2;

   logic [ACC_W-1:0] acc_ff [NCH];
   logic [ACC_W-1:0] acc_in [NCH];
   logic [PW-1:0]    prod   [NCH];
   logic [CW+1:0]    floor_v [NCH];

   always_comb begin
      for (int k = 0; k < NCH; k++) begin
         prod[k] = PW'(pix[k*CW +: CW]) * PW'(weight);
         if (ctl.clear) acc_in[k] = '0;
         else if (ctl.accum) acc_in[k] = acc_ff[k] + ACC_W'(prod[k]);
         else acc_in[k] = acc_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NCH; k++) begin
         acc_ff[k] <= acc_in[k];
      end
   end

   // floor by dropping fraction bits, clamp, zero unused channels
   always_comb begin
      for (int k = 0; k < NCH; k++) begin
         floor_v[k] = acc_ff[k][2*FRAC_BITS +: CW+2];
         if (bps_pkg::COUNT_W'(k) >= chan_n) result[k*CW +: CW] = '0;
         else if (floor_v[k] > (CW+2)'(bps_pkg::PIX_MAX)) result[k*CW +: CW] = bps_pkg::PIX_MAX;
         else result[k*CW +: CW] = floor_v[k][CW-1:0];
      end
   end

endmodule

// ----- rtl/bilinear_pixel_sampler.sv -----
// ----------------------------------------------------------------------------
// bilinear pixel sampler
// pixel store with load and bilinear sample commands
//
//  channel  dir  transfer
//  req_*    in   load one pixel, or sample at a fixed-point location
//  rsp_*    out  one interpolated pixel per sample
//  csr_*    in   image width, image height, channel count
//
//  a load is written into the store at accept; a sample goes from accept to result by:
//  accept, four neighbor reads through the single store port, last
//  accumulate, result register
//  the next item is accepted while a result waits in the output register;
//  a finished sample stalls in its result stage until that register frees
//  reset clears control and registers only; the pixel store has no clear
//  and a pixel must be loaded before a sample reads it
// ----------------------------------------------------------------------------
module bilinear_pixel_sampler #(
   parameter int MAX_WIDTH  = bps_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bps_pkg::DEF_MAX_HEIGHT,
   parameter int FRAC_BITS  = bps_pkg::DEF_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // load_row, load_col, load_ch0..load_ch3, sample_x, sample_y, zero pad
   input  logic [87:0]                        req_tdata,
   // command
   input  logic                               req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_ch0, out_ch1, out_ch2, out_ch3
   output logic [31:0]                        rsp_tdata,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bps_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = bps_pkg::SIZE_W;
   localparam int NW    = bps_pkg::COUNT_W;
   localparam int WW    = 2*FRAC_BITS + 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_LAST = 4'b0100,
      S_DONE = 4'b1000
   } bps_state_type;

   function automatic logic [AW-1:0] pix_addr(logic [SW-1:0] row, logic [SW-1:0] col);
      return AW'(32'(row) * MAX_WIDTH + 32'(col));
   endfunction

   // request fields
   logic [7:0]                         load_row;
   logic [7:0]                         load_col;
   logic [bps_pkg::PIX_W-1:0]          load_pix;
   logic signed [bps_pkg::COORD_W-1:0] sample_x;
   logic signed [bps_pkg::COORD_W-1:0] sample_y;

   assign load_row = req_tdata[7:0];
   assign load_col = req_tdata[15:8];
   assign load_pix = req_tdata[47:16];
   assign sample_x = signed'(req_tdata[65:48]);
   assign sample_y = signed'(req_tdata[83:66]);

   // configuration registers
   logic [SW-1:0] width_ff, width_in;
   logic [SW-1:0] height_ff, height_in;
   logic [NW-1:0] count_ff, count_in;
   logic [NW-1:0] chan_n;
   logic          csr_wr;

   // control
   bps_state_type state_ff, state_in;
   logic [1:0]    rd_idx_ff, rd_idx_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic          req_xfer;
   logic          rsp_load;

   // payload
   bps_pkg::bps_nbr_type nbr_ff, nbr_c;
   logic [FRAC_BITS-1:0] fx_ff, fx_c;
   logic [FRAC_BITS-1:0] fy_ff, fy_c;
   logic [WW-1:0]        weight_ff, weight_in;
   logic [31:0]          rsp_tdata_ff;

   // store and accumulator
   logic                      ram_we;
   logic [AW-1:0]             ram_addr;
   logic [bps_pkg::PIX_W-1:0] ram_rdata;
   logic [SW-1:0]             rd_row;
   logic [SW-1:0]             rd_col;
   logic                      load_ok;
   logic [FRAC_BITS:0]        wx;
   logic [FRAC_BITS:0]        wy;
   logic [WW:0]               wprod;
   bps_pkg::bps_mac_ctl_type  mac_ctl;
   logic [31:0]               mac_result;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      count_in  = count_ff;
      if (csr_wr) begin
         unique case (bps_pkg::bps_reg_type'(csr_paddr[3:2]))
            bps_pkg::REG_IMAGE_WIDTH:   width_in  = csr_pwdata[SW-1:0];
            bps_pkg::REG_IMAGE_HEIGHT:  height_in = csr_pwdata[SW-1:0];
            bps_pkg::REG_CHANNEL_COUNT: count_in  = csr_pwdata[NW-1:0];
            default: ;   // writes beyond the register list are dropped
         endcase
      end
   end

   always_comb begin
      unique case (bps_pkg::bps_reg_type'(csr_paddr[3:2]))
         bps_pkg::REG_IMAGE_WIDTH:   csr_prdata = bps_pkg::CSR_DATA_W'(width_ff);
         bps_pkg::REG_IMAGE_HEIGHT:  csr_prdata = bps_pkg::CSR_DATA_W'(height_ff);
         bps_pkg::REG_CHANNEL_COUNT: csr_prdata = bps_pkg::CSR_DATA_W'(count_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // channel count saturated into 1..4
   always_comb begin
      if (count_ff == '0) chan_n = NW'(1);
      else if (count_ff > bps_pkg::CHAN_MAX) chan_n = bps_pkg::CHAN_MAX;
      else chan_n = count_ff;
   end

   // ---------------- location clamp at accept ----------------
   bps_coord #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_coord (
      .sample_x   (sample_x),
      .sample_y   (sample_y),
      .width_cfg  (width_ff),
      .height_cfg (height_ff),
      .nbr        (nbr_c),
      .frac_x     (fx_c),
      .frac_y     (fy_c)
   );

   // ---------------- sequencer ----------------
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   // result register frees when empty or its transfer completes
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in  = state_ff;
      rd_idx_in = rd_idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_tuser == bps_pkg::CMD_SAMPLE) begin
               state_in  = S_READ;
               rd_idx_in = '0;
            end
         end
         S_READ: begin
            rd_idx_in = rd_idx_ff + 2'd1;
            if (rd_idx_ff == 2'd3) state_in = S_LAST;
         end
         S_LAST: state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_load) rsp_tvalid_in = 1'b1;
      else if (rsp_tready) rsp_tvalid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_idx_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
         width_ff      <= bps_pkg::RST_WIDTH;
         height_ff     <= bps_pkg::RST_HEIGHT;
         count_ff      <= bps_pkg::RST_COUNT;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         count_ff      <= count_in;
      end
   end

   // ---------------- pixel store ----------------
   // loads outside the store are dropped
   assign load_ok = (32'(load_row) < MAX_HEIGHT) && (32'(load_col) < MAX_WIDTH);
   assign ram_we  = req_xfer && (req_tuser == bps_pkg::CMD_LOAD) && load_ok;

   // read order: (r0,c0) (r0,c1) (r1,c0) (r1,c1)
   assign rd_row   = rd_idx_ff[1] ? nbr_ff.r1 : nbr_ff.r0;
   assign rd_col   = rd_idx_ff[0] ? nbr_ff.c1 : nbr_ff.c0;
   assign ram_addr = (state_ff == S_READ) ? pix_addr(rd_row, rd_col)
                                          : pix_addr(SW'(load_row), SW'(load_col));

   bps_ram #(
      .WIDTH (bps_pkg::PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (load_pix),
      .rdata (ram_rdata)
   );

   // ---------------- weights ----------------
   // weight of the neighbor being read; lines up with its read data
   assign wx        = rd_idx_ff[0] ? {1'b0, fx_ff} : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fx_ff});
   assign wy        = rd_idx_ff[1] ? {1'b0, fy_ff} : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fy_ff});
   assign wprod     = (WW+1)'(wx) * (WW+1)'(wy);
   assign weight_in = wprod[WW-1:0];

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         nbr_ff <= nbr_c;
         fx_ff  <= fx_c;
         fy_ff  <= fy_c;
      end
      weight_ff <= weight_in;
      if (rsp_load) rsp_tdata_ff <= mac_result;
   end

   // ---------------- accumulate ----------------
   assign mac_ctl.clear = req_xfer;
   assign mac_ctl.accum = ((state_ff == S_READ) && (rd_idx_ff != 2'd0)) || (state_ff == S_LAST);

   bps_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .pix    (ram_rdata),
      .weight (weight_ff),
      .chan_n (chan_n),
      .result (mac_result)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ----- rtl/bilinear_pixel_sampler_checker.sv -----
// ----------------------------------------------------------------------------
// bilinear pixel sampler checker
// port-level properties of the sampler, bound to the top level
// ----------------------------------------------------------------------------
`include "bilinear_pixel_sampler_assert.svh"

module bilinear_pixel_sampler_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_pready
);

   // a stalled result holds
   `BPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // a sample occupies the block; no item is taken the next cycle
   `BPS_ASSERT_NEXT(a_sample_busy, clock, reset, req_tvalid && req_tready && req_tuser, !req_tready, "item accepted during a sample")

   // a sample cannot produce its result in the following cycle
   `BPS_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_tvalid && req_tready && req_tuser && !rsp_tvalid, !rsp_tvalid, "result too early")

   // reset empties the result register
   `BPS_ASSERT_NEXT(a_reset_rsp, clock, 1'b0, reset, !rsp_tvalid, "result valid after reset")

   // register port never waits
   `BPS_ASSERT_NOW(a_pready, clock, reset, 1'b1, csr_pready, "register port stalled")

endmodule

bind bilinear_pixel_sampler bilinear_pixel_sampler_checker u_checker (.*);

// ----- tb/sv/bilinear_pixel_sampler_test.sv -----
// ----------------------------------------------------------------------------
// bilinear pixel sampler testbench
// fills the pixel store through load transfers, samples at clamped fixed-point
// locations and checks every result against an in-bench interpolator; the
// image size and channel count registers are swept between phases, with
// random gaps on both streams
// ----------------------------------------------------------------------------
module bilinear_pixel_sampler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         HALF_PERIOD  = 6;
   localparam int         RESET_CYCLES = 8;
   // settle time after the streams drain, with slack for a sample in flight
   localparam int         SETTLE_CYCLES = 12;
   localparam int         PHASE_ITEMS  = 80;
   localparam int         IDLE_PCT     = 22;
   // register slot past the end of the list, writes there must be ignored
   localparam logic [1:0] SPARE_REG    = 2'd3;

   typedef logic [bps_pkg::CHANNELS-1:0][bps_pkg::CHAN_W-1:0] pixel_chans_type;

   // one request transfer, fields listed from the top of req_tdata down
   typedef struct packed {
      logic                              cmd;
      logic signed [bps_pkg::COORD_W-1:0] sy;
      logic signed [bps_pkg::COORD_W-1:0] sx;
      pixel_chans_type                   chans;
      logic [7:0]                        col;
      logic [7:0]                        row;
   } pixel_req_type;

   // neighbor coordinates plus the fraction of the clamped location
   typedef struct packed {
      bps_pkg::bps_nbr_type nbr;
      logic [7:0]           fx;
      logic [7:0]           fy;
   } sample_geom_type;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [87:0]                    req_tdata   = '0;
   logic                           req_tuser   = bps_pkg::CMD_LOAD;
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic [31:0]                    rsp_tdata;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [bps_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [bps_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [bps_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // register copies, as written (saturation is applied on use)
   logic [bps_pkg::SIZE_W-1:0]  width_reg   = bps_pkg::RST_WIDTH;
   logic [bps_pkg::SIZE_W-1:0]  height_reg  = bps_pkg::RST_HEIGHT;
   logic [bps_pkg::COUNT_W-1:0] chan_reg    = bps_pkg::RST_COUNT;

   // pixel store copy, and which entries the stimulus has already loaded
   logic [bps_pkg::PIX_W-1:0] pixel_mem  [0:65535];
   bit                        loaded_map [0:65535];

   pixel_req_type      pending_reqs[$];
   pixel_chans_type    expected_pixels[$];
   pixel_req_type      cur_req;
   bit                 req_sent = 1'b0;
   bit                 calm     = 1'b0;
   int                 queued_count = 0;
   int                 errors   = 0;

   bilinear_pixel_sampler uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // interpolator
   // ------------------------------------------------------------------------

   // width and height registers saturate into 1..256 when used
   function automatic logic [bps_pkg::SIZE_W-1:0] usable_size(
         input logic [bps_pkg::SIZE_W-1:0] v);
      if (v == 9'd0) return 9'd1;
      if (v > 9'd256) return 9'd256;
      return v;
   endfunction

   // clamp a coordinate to [0, (size-1) << 8]
   function automatic logic [15:0] clamp_pos(input logic signed [bps_pkg::COORD_W-1:0] pos,
                                             input logic [bps_pkg::SIZE_W-1:0] size);
      int top;
      top = (int'(size) - 1) * 256;
      if (pos < 0) return 16'd0;
      if (int'(pos) > top) return top[15:0];
      return pos[15:0];
   endfunction

   function automatic logic [15:0] pixel_addr(input logic [bps_pkg::SIZE_W-1:0] row,
                                              input logic [bps_pkg::SIZE_W-1:0] col);
      return {row[7:0], col[7:0]};
   endfunction

   // the four neighbors under the current register values; the +1 neighbor
   // folds back onto the last column or row at the right or bottom edge
   function automatic sample_geom_type locate_sample(
         input logic signed [bps_pkg::COORD_W-1:0] sx,
         input logic signed [bps_pkg::COORD_W-1:0] sy);
      logic [bps_pkg::SIZE_W-1:0] w;
      logic [bps_pkg::SIZE_W-1:0] h;
      logic [15:0]                xc;
      logic [15:0]                yc;
      sample_geom_type            g;
      w  = usable_size(width_reg);
      h  = usable_size(height_reg);
      xc = clamp_pos(sx, w);
      yc = clamp_pos(sy, h);
      g.nbr.c0 = {1'b0, xc[15:8]};
      g.nbr.r0 = {1'b0, yc[15:8]};
      g.fx = xc[7:0];
      g.fy = yc[7:0];
      g.nbr.c1 = (g.nbr.c0 + 9'd1 < w) ? g.nbr.c0 + 9'd1 : w - 9'd1;
      g.nbr.r1 = (g.nbr.r0 + 9'd1 < h) ? g.nbr.r0 + 9'd1 : h - 9'd1;
      return g;
   endfunction

   // exact bilinear sum, floored and clamped; unused channels give zero
   function automatic pixel_chans_type interpolate_pixel(
         input logic signed [bps_pkg::COORD_W-1:0] sx,
         input logic signed [bps_pkg::COORD_W-1:0] sy);
      sample_geom_type             g;
      logic [bps_pkg::PIX_W-1:0]   nb [4];
      logic [31:0]                 wt [4];
      logic [31:0]                 acc;
      logic [bps_pkg::COUNT_W-1:0] n;
      pixel_chans_type             res;
      g = locate_sample(sx, sy);
      nb[0] = pixel_mem[pixel_addr(g.nbr.r0, g.nbr.c0)];
      nb[1] = pixel_mem[pixel_addr(g.nbr.r0, g.nbr.c1)];
      nb[2] = pixel_mem[pixel_addr(g.nbr.r1, g.nbr.c0)];
      nb[3] = pixel_mem[pixel_addr(g.nbr.r1, g.nbr.c1)];
      wt[0] = (32'd256 - g.fx) * (32'd256 - g.fy);
      wt[1] = 32'(g.fx) * (32'd256 - g.fy);
      wt[2] = (32'd256 - g.fx) * 32'(g.fy);
      wt[3] = 32'(g.fx) * 32'(g.fy);
      n = (chan_reg == 3'd0) ? 3'd1 :
          ((chan_reg > bps_pkg::CHAN_MAX) ? bps_pkg::CHAN_MAX : chan_reg);
      for (int k = 0; k < bps_pkg::CHANNELS; k++) begin
         res[k] = '0;
         if (k < n) begin
            acc = 32'(nb[0][8*k +: 8]) * wt[0] + 32'(nb[1][8*k +: 8]) * wt[1]
                + 32'(nb[2][8*k +: 8]) * wt[2] + 32'(nb[3][8*k +: 8]) * wt[3];
            acc = acc >> 16;
            res[k] = (acc > 32'(bps_pkg::PIX_MAX)) ? bps_pkg::PIX_MAX : acc[7:0];
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------------

   // load transfer; the unused sample fields carry random bits
   task automatic queue_load(input logic [7:0] row, input logic [7:0] col,
                             input logic [31:0] chans);
      pixel_req_type it;
      it.cmd   = bps_pkg::CMD_LOAD;
      it.row   = row;
      it.col   = col;
      it.chans = chans;
      it.sx    = bps_pkg::COORD_W'($urandom());
      it.sy    = bps_pkg::COORD_W'($urandom());
      loaded_map[{row, col}] = 1'b1;
      pending_reqs.insert(pending_reqs.size(), it);
      queued_count++;
   endtask

   // sample transfer; any neighbor not yet loaded gets a load ahead of it,
   // so the never-written part of the store is never read
   task automatic queue_sample(input logic signed [bps_pkg::COORD_W-1:0] sx,
                               input logic signed [bps_pkg::COORD_W-1:0] sy);
      sample_geom_type g;
      pixel_req_type   it;
      g = locate_sample(sx, sy);
      if (!loaded_map[pixel_addr(g.nbr.r0, g.nbr.c0)])
         queue_load(g.nbr.r0[7:0], g.nbr.c0[7:0], $urandom());
      if (!loaded_map[pixel_addr(g.nbr.r0, g.nbr.c1)])
         queue_load(g.nbr.r0[7:0], g.nbr.c1[7:0], $urandom());
      if (!loaded_map[pixel_addr(g.nbr.r1, g.nbr.c0)])
         queue_load(g.nbr.r1[7:0], g.nbr.c0[7:0], $urandom());
      if (!loaded_map[pixel_addr(g.nbr.r1, g.nbr.c1)])
         queue_load(g.nbr.r1[7:0], g.nbr.c1[7:0], $urandom());
      it.cmd   = bps_pkg::CMD_SAMPLE;
      it.row   = 8'($urandom());
      it.col   = 8'($urandom());
      it.chans = $urandom();
      it.sx    = sx;
      it.sy    = sy;
      pending_reqs.insert(pending_reqs.size(), it);
      queued_count++;
   endtask

   // coordinate mix: full 18-bit range, whole pixels, straddling the far
   // edge, and mostly somewhere in or just around the image
   function automatic logic signed [bps_pkg::COORD_W-1:0] rand_coord(
         input logic [bps_pkg::SIZE_W-1:0] size);
      int span;
      span = int'(size) * 256;
      case ($urandom_range(9))
         0, 1: return bps_pkg::COORD_W'($urandom());
         2: return bps_pkg::COORD_W'(int'($urandom_range(int'(size) - 1)) * 256);
         3: return bps_pkg::COORD_W'(span - 256 + int'($urandom_range(511)));
         default: return bps_pkg::COORD_W'(int'($urandom_range(span + 255)) - 256);
      endcase
   endfunction

   // register write: setup cycle, then access cycle until pready
   task automatic write_csr(input logic [1:0] idx,
                            input logic [bps_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = bps_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         bps_pkg::REG_IMAGE_WIDTH:   width_reg  = data[bps_pkg::SIZE_W-1:0];
         bps_pkg::REG_IMAGE_HEIGHT:  height_reg = data[bps_pkg::SIZE_W-1:0];
         bps_pkg::REG_CHANNEL_COUNT: chan_reg   = data[bps_pkg::COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // block idle: nothing queued or offered, no result outstanding, and a
   // load that yields no result has had time to finish
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // driver: offers the next queued item at the falling edge, random gaps
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (req_sent || !req_tvalid)) begin
         req_sent = 1'b0;
         if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            cur_req = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            // row, col, ch0..ch3, sample_x, sample_y, zero pad
            req_tdata  <= {4'b0, cur_req.sy, cur_req.sx, cur_req.chans,
                           cur_req.col, cur_req.row};
            req_tuser  <= cur_req.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      // result side back-pressure
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // ------------------------------------------------------------------------
   // request monitor: every accepted transfer updates the store copy or
   // queues the expected pixel
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         req_sent = 1'b1;
         if (cur_req.cmd == bps_pkg::CMD_LOAD)
            pixel_mem[{cur_req.row, cur_req.col}] = cur_req.chans;
         else
            expected_pixels.insert(expected_pixels.size(),
                                   interpolate_pixel(cur_req.sx, cur_req.sy));
      end
   end

   // ------------------------------------------------------------------------
   // result monitor: in-order compare against the oldest expected pixel
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_chans_type want;
      pixel_chans_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_pixels.size() == 0) begin
            $display("%0t: result with none expected, actual ch0..3 %0d %0d %0d %0d",
                     $time, got[0], got[1], got[2], got[3]);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            if (got[0] !== want[0] || got[1] !== want[1] ||
                got[2] !== want[2] || got[3] !== want[3]) begin
               $display("%0t: pixel mismatch, expected ch0..3 %0d %0d %0d %0d, actual %0d %0d %0d %0d",
                        $time, want[0], want[1], want[2], want[3],
                        got[0], got[1], got[2], got[3]);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      // register sweep: ones, twos, zero (saturates up), over-range
      // (saturates down), odd sizes, full size
      logic [bps_pkg::SIZE_W-1:0]  cfg_w [8] = '{9'd1, 9'd2, 9'd0, 9'd511, 9'd5, 9'd16,
                                                 9'd256, 9'd3};
      logic [bps_pkg::SIZE_W-1:0]  cfg_h [8] = '{9'd1, 9'd2, 9'd0, 9'd300, 9'd3, 9'd16,
                                                 9'd256, 9'd256};
      logic [bps_pkg::COUNT_W-1:0] cfg_n [8] = '{3'd1, 3'd2, 3'd0, 3'd7, 3'd3, 3'd4,
                                                 3'd4, 3'd2};
      logic [bps_pkg::SIZE_W-1:0]  w;
      logic [bps_pkg::SIZE_W-1:0]  h;
      logic [bps_pkg::SIZE_W-1:0]  n;
      int                          goal;

      // directed part, reset geometry 256 x 256, four channels
      queue_load(8'd0, 8'd0, 32'h0000_0000);
      queue_load(8'd0, 8'd1, 32'hFFFF_FFFF);
      queue_load(8'd1, 8'd0, 32'hFF00_FF00);
      queue_load(8'd1, 8'd1, 32'h00FF_00FF);
      queue_sample(-18'sd131072, -18'sd131072);   // far outside, clamps to origin
      queue_sample(18'sd0, 18'sd0);
      queue_sample(18'sd128, 18'sd128);           // half way on both axes
      queue_sample(18'sd255, 18'sd255);           // largest fraction
      queue_sample(18'sd256, 18'sd0);             // whole pixel
      queue_load(8'd255, 8'd255, 32'hFFFF_FFFF);
      queue_load(8'd255, 8'd254, 32'h0000_0000);
      queue_load(8'd254, 8'd255, 32'hFFFF_FFFF);
      queue_load(8'd254, 8'd254, 32'h0000_0000);
      queue_sample(18'sd131071, 18'sd131071);     // clamps to the last pixel
      queue_sample(18'sd65408, 18'sd65408);       // just past the edge
      queue_sample(18'sd65152, 18'sd65152);       // last cell, half way on both axes
      queue_sample(18'sd0, 18'sd131071);          // bottom edge
      queue_sample(18'sd131071, 18'sd0);          // right edge
      queue_sample(-18'sd1, 18'sd300);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait_idle();

      goal = queued_count;
      for (int p = 0; p < 11; p++) begin
         if (p < 8) begin
            w = cfg_w[p];
            h = cfg_h[p];
            n = 9'(cfg_n[p]);
         end else begin
            w = 9'($urandom_range(511));
            h = 9'($urandom_range(511));
            n = 9'($urandom_range(7));
         end
         // upper data bits are random and must not matter
         write_csr(bps_pkg::REG_IMAGE_WIDTH,   ($urandom() & ~32'h1FF) | 32'(w));
         write_csr(bps_pkg::REG_IMAGE_HEIGHT,  ($urandom() & ~32'h1FF) | 32'(h));
         write_csr(bps_pkg::REG_CHANNEL_COUNT, ($urandom() & ~32'h7) | 32'(n[2:0]));
         write_csr(SPARE_REG, $urandom());

         // one phase runs with both streams never idling
         calm = (p == 5);
         goal += PHASE_ITEMS;
         while (queued_count < goal) begin
            if ($urandom_range(99) < 25) begin
               // loads: half inside the image area, half anywhere in the store
               if ($urandom_range(1) == 0)
                  queue_load(8'($urandom_range(int'(usable_size(height_reg)) - 1)),
                             8'($urandom_range(int'(usable_size(width_reg)) - 1)),
                             $urandom());
               else
                  queue_load(8'($urandom()), 8'($urandom()), $urandom());
            end else begin
               queue_sample(rand_coord(usable_size(width_reg)),
                            rand_coord(usable_size(height_reg)));
            end
         end
         wait_idle();
      end

      if (errors == 0)
         $display("[bilinear_pixel_sampler] OK");
      else
         $display("[bilinear_pixel_sampler] ERROR");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5ms;
      $display("[bilinear_pixel_sampler] ERROR");
      $finish;
   end

endmodule
